/* rtl/variable_length_bit_packer_macros.svh */
// Assertion macros for the variable-length bit packer.
// Used by the top level; expects a clock named clk and a reset named rst in scope.
`ifndef VARIABLE_LENGTH_BIT_PACKER_MACROS_SVH
`define VARIABLE_LENGTH_BIT_PACKER_MACROS_SVH

// same-cycle implication
`define VLBP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vlbp assertion failed");

// next-cycle implication
`define VLBP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vlbp assertion failed");

`endif

/* rtl/vlbp_pkg.sv */
// Package for the variable-length bit packer: field widths, command codes,
// request and result types. No dependencies.
`timescale 1ns / 1ps
package vlbp_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int CODE_W        = 32;
  localparam int LEN_W         = 6;
  localparam int OUT_W         = 32;
  localparam int CNT_W         = 6;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_FLUSH  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } code_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] out_word;
    logic [CNT_W-1:0] out_valid_bits;
  } word_res_t;

endpackage

/* rtl/vlbp_code_if.sv */
// Input channel of the bit packer: valid/ready plus one code request.
// Depends on vlbp_pkg.
`timescale 1ns / 1ps
interface vlbp_code_if;
  logic                                 valid;
  logic                                 ready;
  vlbp_pkg::cmd_t                       cmd;
  logic [vlbp_pkg::CODE_W-1:0]          code_bits;
  logic [vlbp_pkg::LEN_W-1:0]           code_length;

  modport source (output valid, cmd, code_bits, code_length, input ready);
  modport sink   (input valid, cmd, code_bits, code_length, output ready);
endinterface

/* rtl/vlbp_word_if.sv */
// Output channel of the bit packer: valid/ready plus one packed word.
// Depends on vlbp_pkg.
`timescale 1ns / 1ps
interface vlbp_word_if;
  logic                                 valid;
  logic                                 ready;
  logic [vlbp_pkg::OUT_W-1:0]           out_word;
  logic [vlbp_pkg::CNT_W-1:0]           out_valid_bits;

  modport source (output valid, out_word, out_valid_bits, input ready);
  modport sink   (input valid, out_word, out_valid_bits, output ready);
endinterface

/* rtl/vlbp_pack_core.sv */
// Combinational packing step: merges one request into the accumulator state
// and produces the next state and at most one packed word. Depends on vlbp_pkg.
`timescale 1ns / 1ps
module vlbp_pack_core #(
  parameter int WORD_BITS = vlbp_pkg::WORD_BITS_DEF
) (
  input  vlbp_pkg::code_req_t          req,
  input  logic [WORD_BITS-1:0]         acc,
  input  logic [$clog2(WORD_BITS)-1:0] fill,
  output logic [WORD_BITS-1:0]         acc_next,
  output logic [$clog2(WORD_BITS)-1:0] fill_next,
  output logic                         res_valid,
  output vlbp_pkg::word_res_t          res
);
  import vlbp_pkg::*;

  localparam int XW    = WORD_BITS + 32;
  localparam int FW    = $clog2(WORD_BITS);
  localparam int TW    = $clog2(WORD_BITS + 32);
  localparam int LIMIT = (WORD_BITS < CODE_W) ? WORD_BITS : CODE_W;

  logic [LEN_W-1:0]  len;
  logic [CODE_W-1:0] code;
  logic [TW-1:0]     total;
  logic [TW-1:0]     rem;
  logic [TW-1:0]     up_shift;
  logic [XW-1:0]     acc_x;
  logic [XW-1:0]     code_x;
  logic [XW-1:0]     cat_x;
  logic [XW-1:0]     head_x;
  logic [XW-1:0]     word_x;
  logic [XW-1:0]     rem_x;

  // saturate length, keep only the low len bits of the code
  assign len    = (req.code_length > LEN_W'(LIMIT)) ? LEN_W'(LIMIT) : req.code_length;
  assign code   = req.code_bits & ~({CODE_W{1'b1}} << len);
  assign acc_x  = XW'(acc);
  assign code_x = XW'(code);

  assign total    = TW'(fill) + TW'(len);
  assign rem      = total - TW'(WORD_BITS);
  assign up_shift = TW'(WORD_BITS) - TW'(fill);

  assign cat_x  = (acc_x << len) | code_x;
  assign head_x = acc_x << up_shift;          // pending bits left-aligned
  assign word_x = head_x | (code_x >> rem);
  assign rem_x  = code_x & ~({XW{1'b1}} << rem);

  always_comb begin
    acc_next      = acc;
    fill_next     = fill;
    res_valid     = 1'b0;
    res.out_word       = OUT_W'(word_x[WORD_BITS-1:0]);
    res.out_valid_bits = CNT_W'(WORD_BITS);
    if (req.cmd == CMD_FLUSH) begin
      acc_next  = '0;
      fill_next = '0;
      res.out_word       = OUT_W'(head_x[WORD_BITS-1:0]);
      res.out_valid_bits = CNT_W'(fill);
      res_valid = (fill != '0);
    end else if (len != '0) begin
      if (total < TW'(WORD_BITS)) begin
        acc_next  = cat_x[WORD_BITS-1:0];
        fill_next = FW'(total);
      end else begin
        // word complete; overflow bits start the next word
        acc_next  = rem_x[WORD_BITS-1:0];
        fill_next = FW'(rem);
        res_valid = 1'b1;
      end
    end
  end

endmodule

/* rtl/variable_length_bit_packer.sv */
// Variable-length bit packer, MSB first, into WORD_BITS-bit words.
// Requests enter the input register; words they complete enter the output register.
// Throughput: one request per cycle (one accumulator update) while output drains.
// Output register lets the next request enter while a word waits to be taken.
// Reset (rst, synchronous): accumulator and fill count clear, both stages empty.
`timescale 1ns / 1ps
`include "variable_length_bit_packer_macros.svh"
module variable_length_bit_packer #(
  parameter int WORD_BITS = vlbp_pkg::WORD_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  vlbp_code_if.sink   codes,
  vlbp_word_if.source words
);
  import vlbp_pkg::*;

  localparam int FW = $clog2(WORD_BITS);
  localparam int TW = $clog2(WORD_BITS + 32);

  code_req_t              s1;
  logic                   s1_valid;
  logic [WORD_BITS-1:0]   acc;
  logic [FW-1:0]          fill;
  logic [WORD_BITS-1:0]   acc_next;
  logic [FW-1:0]          fill_next;
  logic                   res_valid;
  word_res_t              res;
  word_res_t              out_reg;
  logic                   out_valid;
  logic                   advance;
  logic                   in_take;

  assign advance     = s1_valid && (!out_valid || words.ready);
  assign codes.ready = !s1_valid || advance;
  assign in_take     = codes.valid && codes.ready;

  vlbp_pack_core #(.WORD_BITS(WORD_BITS)) u_core (
    .req       (s1),
    .acc       (acc),
    .fill      (fill),
    .acc_next  (acc_next),
    .fill_next (fill_next),
    .res_valid (res_valid),
    .res       (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (codes.ready) begin
      s1_valid <= codes.valid;
    end
    if (in_take) begin
      s1.cmd         <= codes.cmd;
      s1.code_bits   <= codes.code_bits;
      s1.code_length <= codes.code_length;
    end
  end

  // packing state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      fill <= '0;
    end else if (advance) begin
      acc  <= acc_next;
      fill <= fill_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !words.ready) || (advance && res_valid);
    end
    if (advance && res_valid) out_reg <= res;
  end

  assign words.valid          = out_valid;
  assign words.out_word       = out_reg.out_word;
  assign words.out_valid_bits = out_reg.out_valid_bits;

  `VLBP_ASSERT_IMP(a_fill_range, 1'b1, TW'(fill) < TW'(WORD_BITS))
  `VLBP_ASSERT_NXT(a_flush_clears, advance && (s1.cmd == CMD_FLUSH), fill == '0)
  `VLBP_ASSERT_NXT(a_full_count, advance && res_valid && (s1.cmd == CMD_APPEND), out_valid && (words.out_valid_bits == CNT_W'(WORD_BITS)))
  `VLBP_ASSERT_NXT(a_take_loads, in_take, s1_valid)

endmodule

/* dv/variable_length_bit_packer_tb.sv */
`timescale 1ns / 1ps
// Testbench for variable_length_bit_packer: a directed request table, then random
// append/flush requests; each output word is checked against the table's word or an in-bench packer.
// Depends on vlbp_pkg, vlbp_code_if and vlbp_word_if.
module variable_length_bit_packer_tb;
  import vlbp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_REQS  = 400;
  localparam int HOLD_AT_WORD = 60;
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_PCT     = 12;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_QUIET,
    ROW_WORD
  } row_chk_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
    row_chk_t          chk;
    logic [OUT_W-1:0]  word;
    logic [CNT_W-1:0]  cnt;
  } plan_row_t;

  // Typed rows hold the word that can be read straight off the packing rules.
  plan_row_t plan [22] = '{
    '{CMD_FLUSH,  32'hFFFF_FFFF, 6'd32, ROW_QUIET,   32'h0,         6'd0},
    '{CMD_APPEND, 32'hFFFF_FFFF, 6'd0,  ROW_QUIET,   32'h0,         6'd0},
    '{CMD_APPEND, 32'hFFFF_FFFF, 6'd32, ROW_WORD,    32'hFFFF_FFFF, 6'd32},
    '{CMD_APPEND, 32'h0000_0000, 6'd32, ROW_WORD,    32'h0000_0000, 6'd32},
    '{CMD_APPEND, 32'hA5A5_A5A5, 6'd63, ROW_WORD,    32'hA5A5_A5A5, 6'd32},
    '{CMD_APPEND, 32'hFFFF_FFFF, 6'd1,  ROW_QUIET,   32'h0,         6'd0},
    '{CMD_FLUSH,  32'h0000_0000, 6'd0,  ROW_WORD,    32'h8000_0000, 6'd1},
    '{CMD_APPEND, 32'h7FFF_FFFF, 6'd31, ROW_QUIET,   32'h0,         6'd0},
    '{CMD_APPEND, 32'h0000_0002, 6'd2,  ROW_PREDICT, 32'h0,         6'd0},
    '{CMD_FLUSH,  32'h0000_0000, 6'd0,  ROW_PREDICT, 32'h0,         6'd0},
    '{CMD_APPEND, 32'h1234_5678, 6'd33, ROW_WORD,    32'h1234_5678, 6'd32},
    '{CMD_APPEND, 32'hFFFF_ABCD, 6'd16, ROW_QUIET,   32'h0,         6'd0},
    '{CMD_APPEND, 32'h0000_1234, 6'd16, ROW_WORD,    32'hABCD_1234, 6'd32},
    '{CMD_APPEND, 32'h0000_0015, 6'd5,  ROW_PREDICT, 32'h0,         6'd0},
    '{CMD_APPEND, 32'hDEAD_BEEF, 6'd20, ROW_PREDICT, 32'h0,         6'd0},
    '{CMD_FLUSH,  32'hCAFE_F00D, 6'd17, ROW_PREDICT, 32'h0,         6'd0},
    '{CMD_APPEND, 32'h0000_0000, 6'd31, ROW_QUIET,   32'h0,         6'd0},
    '{CMD_APPEND, 32'hFFFF_FFFF, 6'd32, ROW_PREDICT, 32'h0,         6'd0},
    '{CMD_FLUSH,  32'h0000_0000, 6'd0,  ROW_WORD,    32'hFFFF_FFFE, 6'd31},
    '{CMD_FLUSH,  32'hFFFF_FFFF, 6'd63, ROW_QUIET,   32'h0,         6'd0},
    '{CMD_APPEND, 32'h0000_0080, 6'd7,  ROW_PREDICT, 32'h0,         6'd0},
    '{CMD_FLUSH,  32'h0000_0000, 6'd0,  ROW_PREDICT, 32'h0,         6'd0}
  };

  logic clk;
  logic rst;

  vlbp_code_if code_ch ();
  vlbp_word_if word_ch ();

  variable_length_bit_packer dut (
    .clk   (clk),
    .rst   (rst),
    .codes (code_ch),
    .words (word_ch)
  );

  // packer state mirror
  logic [31:0]     pk_acc;
  logic [5:0]      pk_fill;
  word_res_t       pending_words[$];
  int unsigned     reqs_sent;
  int unsigned     flushes_sent;
  int unsigned     words_seen;
  int unsigned     error_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d words outstanding", cycles,
             pending_words.size());
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Appends or flushes one request; returns 1 when a word comes out.
  function automatic bit pack_code(input code_req_t r, output word_res_t w);
    logic [5:0]  n;
    logic [31:0] code;
    logic [6:0]  total;
    logic [5:0]  rem;
    w = '0;
    if (r.cmd == CMD_FLUSH) begin
      if (pk_fill == 6'd0) begin
        pk_acc = '0;
        return 1'b0;
      end
      w.out_word       = pk_acc << (32 - pk_fill);
      w.out_valid_bits = pk_fill;
      pk_acc  = '0;
      pk_fill = '0;
      return 1'b1;
    end
    n = (r.code_length > 6'd32) ? 6'd32 : r.code_length;
    if (n == 6'd0) return 1'b0;
    code  = (n == 6'd32) ? r.code_bits : (r.code_bits & ((32'd1 << n) - 32'd1));
    total = 7'(pk_fill) + 7'(n);
    if (total < 7'd32) begin
      pk_acc  = (pk_acc << n) | code;
      pk_fill = total[5:0];
      return 1'b0;
    end
    rem = 6'(total - 7'd32);
    // acc is zero when empty, so the shift by 32 drops out harmlessly
    w.out_word       = (pk_acc << (32 - pk_fill)) | (code >> rem);
    w.out_valid_bits = 6'd32;
    pk_acc  = code & ((32'd1 << rem) - 32'd1);
    pk_fill = rem;
    return 1'b1;
  endfunction

  function automatic code_req_t random_request();
    code_req_t   r;
    int unsigned pick;
    pick        = $urandom_range(99);
    r.cmd       = (pick < 10) ? CMD_FLUSH : CMD_APPEND;
    r.code_bits = $urandom;
    if (pick < 10) begin
      r.code_length = 6'($urandom_range(63));
    end else if (pick < 14) begin
      r.code_length = 6'd0;
    end else if (pick < 20) begin
      r.code_length = 6'($urandom_range(63, 33));
    end else if (pick < 28) begin
      r.code_length = 6'd32;
    end else begin
      r.code_length = 6'($urandom_range(31, 1));
    end
    return r;
  endfunction

  // Holds the request on the channel until it is taken.
  task automatic offer_request(input code_req_t r);
    logic took;
    code_ch.valid       <= 1'b1;
    code_ch.cmd         <= r.cmd;
    code_ch.code_bits   <= r.code_bits;
    code_ch.code_length <= r.code_length;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = code_ch.ready;
      @(posedge clk);
    end
    reqs_sent++;
    if (r.cmd == CMD_FLUSH) flushes_sent++;
  endtask

  task automatic maybe_idle(input bit allow);
    if (allow && $urandom_range(99) < IDLE_PCT) begin
      code_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_pause();
    code_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic check_word(input word_res_t got);
    word_res_t want;
    words_seen++;
    if (pending_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word %h bits %0d", got.out_word,
                                got.out_valid_bits));
      return;
    end
    want = pending_words.pop_front();
    if (got.out_word !== want.out_word)
      report_mismatch($sformatf("word %0d: out_word %h, want %h", words_seen,
                                got.out_word, want.out_word));
    if (got.out_valid_bits !== want.out_valid_bits)
      report_mismatch($sformatf("word %0d: out_valid_bits %0d, want %0d", words_seen,
                                got.out_valid_bits, want.out_valid_bits));
  endtask

  initial begin : word_sink
    logic        took;
    word_res_t   seen;
    int unsigned hold_left;
    bit          hold_done;
    took      = 1'b0;
    seen      = '0;
    hold_left = 0;
    hold_done = 1'b0;
    word_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (took) check_word(seen);
      if (!rst && !hold_done && words_seen >= HOLD_AT_WORD) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (rst) begin
        word_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        // long hold-off: packer output backs up and stalls the request side
        hold_left--;
        word_ch.ready <= 1'b0;
      end else if (words_seen >= 130 && words_seen < 180) begin
        word_ch.ready <= 1'b1;
      end else begin
        word_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
      @(negedge clk);
      took                = word_ch.valid && word_ch.ready;
      seen.out_word       = word_ch.out_word;
      seen.out_valid_bits = word_ch.out_valid_bits;
    end
  end

  initial begin : stimulus
    code_req_t r;
    word_res_t w;
    bit        fired;
    rst                 <= 1'b1;
    code_ch.valid       <= 1'b0;
    code_ch.cmd         <= CMD_APPEND;
    code_ch.code_bits   <= '0;
    code_ch.code_length <= '0;
    pk_acc       = '0;
    pk_fill      = '0;
    reqs_sent    = 0;
    flushes_sent = 0;
    words_seen   = 0;
    error_count  = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      maybe_idle(1'b1);
      r.cmd         = plan[i].cmd;
      r.code_bits   = plan[i].bits;
      r.code_length = plan[i].len;
      offer_request(r);
      fired = pack_code(r, w);
      if (plan[i].chk == ROW_WORD) begin
        w.out_word       = plan[i].word;
        w.out_valid_bits = plan[i].cnt;
        pending_words.push_back(w);
      end else if (plan[i].chk == ROW_PREDICT && fired) begin
        pending_words.push_back(w);
      end
    end
    drain_pause();

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS / 2) drain_pause();
      maybe_idle(n < 250 || n >= 330);
      r = random_request();
      offer_request(r);
      if (pack_code(r, w)) pending_words.push_back(w);
    end
    code_ch.valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("sent %0d requests (%0d flushes), checked %0d packed words, %0d mismatches",
             reqs_sent, flushes_sent, words_seen, error_count);
    $display("covered overlong and zero lengths, exact fills, empty flushes and a long stall");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
